// ===== rtl/ecc_pkg.sv =====
// Shared widths, calendar constants and calendar arithmetic functions.
package ecc_pkg;

    localparam int YEAR_W   = 12;
    localparam int MON_W    = 4;
    localparam int DAY_W    = 5;
    localparam int HOUR_W   = 5;
    localparam int MIN_W    = 6;
    localparam int SEC_W    = 6;
    localparam int WD_W     = 3;
    localparam int DAYS_W   = 20;   // epoch day count below 4096-01-01
    localparam int EDAYS_W  = 21;   // epoch day count of search candidates
    localparam int DOY_W    = 9;
    localparam int HMS_W    = 17;
    localparam int PROD_W   = 37;   // day count times seconds per day
    localparam int YSRCH_W  = 14;   // year arithmetic inside the search

    localparam int SECONDS_WIDTH_DEF = 36;

    localparam int SEC_PER_DAY  = 86400;
    localparam int SEC_PER_HOUR = 3600;
    localparam int SEC_PER_MIN  = 60;

    localparam logic [YEAR_W-1:0] EPOCH_YEAR = 12'd1970;
    localparam logic [21:0]       DB_EPOCH   = 22'd719528;  // days from year 0 to 1970
    localparam logic [PROD_W-1:0] END_SECS   = 37'd67090118400;  // 4096-01-01 00:00:00

    localparam logic [MON_W-1:0] MON_JAN = 4'd1;
    localparam logic [MON_W-1:0] MON_FEB = 4'd2;
    localparam logic [MON_W-1:0] MON_DEC = 4'd12;

    // floor(x / 100), exact for x below 43699
    function automatic logic [YSRCH_W-1:0] div100(input logic [YSRCH_W-1:0] x);
        logic [26:0] p;
        p = 27'(x) * 27'd5243;
        return YSRCH_W'(p >> 19);
    endfunction

    function automatic logic is_leap(input logic [YEAR_W-1:0] y);
        logic [YSRCH_W-1:0] q;
        logic [YSRCH_W-1:0] r;
        q = div100(YSRCH_W'(y));
        r = YSRCH_W'(y) - q * 14'd100;
        return (y[1:0] == 2'd0) && ((r != '0) || (q[1:0] == 2'd0));
    endfunction

    // days from 1970-01-01 to the first day of year y
    function automatic logic [EDAYS_W-1:0] epoch_days(input logic [YSRCH_W-1:0] y);
        logic [21:0] t;
        t = 22'(y) * 22'd365 + 22'((y + 14'd3) >> 2)
            + 22'(div100(y + 14'd399) >> 2) - 22'(div100(y + 14'd99)) - DB_EPOCH;
        return t[EDAYS_W-1:0];
    endfunction

    function automatic logic [DAY_W-1:0] month_len(input logic [MON_W-1:0] m,
                                                   input logic lp);
        logic [DAY_W-1:0] d;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    d = 5'd30;
            4'd2:                                       d = lp ? 5'd29 : 5'd28;
            default:                                    d = 5'd0;
        endcase
        return d;
    endfunction

    // days of the year that precede month m
    function automatic logic [DOY_W-1:0] days_before_month(input logic [MON_W-1:0] m,
                                                            input logic lp);
        logic [DOY_W-1:0] d;
        case (m)
            4'd1:    d = 9'd0;
            4'd2:    d = 9'd31;
            4'd3:    d = 9'd59;
            4'd4:    d = 9'd90;
            4'd5:    d = 9'd120;
            4'd6:    d = 9'd151;
            4'd7:    d = 9'd181;
            4'd8:    d = 9'd212;
            4'd9:    d = 9'd243;
            4'd10:   d = 9'd273;
            4'd11:   d = 9'd304;
            4'd12:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d + DOY_W'(lp && (m > MON_FEB));
    endfunction

    // x mod 7 by folding octal digits (8 is 1 mod 7)
    function automatic logic [WD_W-1:0] mod7(input logic [EDAYS_W-1:0] x);
        logic [5:0] s1;
        logic [3:0] s2;
        s1 = '0;
        for (int i = 0; i < 7; i++) begin
            s1 = s1 + 6'(x[3*i +: 3]);
        end
        s2 = 4'(s1[5:3]) + 4'(s1[2:0]);
        return (s2 >= 4'd7) ? 3'(s2 - 4'd7) : s2[2:0];
    endfunction

endpackage

// ===== rtl/ecc_divc.sv =====
// Pipelined divider by a constant: pre-shift, reciprocal multiplication, remainder.
module ecc_divc #(
    parameter int DW  = 17,
    parameter int QW  = 5,
    parameter int DIV = 3600,
    parameter int PW  = 1,
    localparam int DVW = $clog2(DIV + 1)
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_vld,
    input  logic [DW-1:0]  i_num,
    input  logic [PW-1:0]  i_pl,
    output logic           o_vld,
    output logic [QW-1:0]  o_q,
    output logic [DVW-1:0] o_rem,
    output logic [PW-1:0]  o_pl
);
    // power-of-two factor of the divisor
    function automatic int trail_zeros(input int v);
        int n;
        int w;
        n = 0;
        w = v;
        while ((w > 1) && ((w & 1) == 0)) begin
            w = w >> 1;
            n++;
        end
        return n;
    endfunction

    localparam int SH  = trail_zeros(DIV);
    localparam int OD  = DIV >> SH;     // odd part of the divisor
    localparam int NW  = DW - SH;       // numerator width after the pre-shift
    localparam int LW  = $clog2(OD);
    localparam int KW  = NW + LW;
    // ceil(2^KW / OD): exact floor quotient for every NW-bit numerator
    localparam longint MAG = ((longint'(1) << KW) + longint'(OD) - longint'(1))
                             / longint'(OD);
    localparam int MW  = $clog2(MAG + 1);
    localparam int PRW = NW + MW;

    logic [NW-1:0]  w_xs;
    logic [QW-1:0]  w_q;
    logic [DW-1:0]  w_rem;

    logic [PRW-1:0] r_prod;
    logic [DW-1:0]  r_num1;
    logic [DW-1:0]  r_num2;
    logic [QW-1:0]  r_q2;
    logic [DW-1:0]  r_qd2;
    logic [QW-1:0]  r_q3;
    logic [DVW-1:0] r_rem3;
    logic [PW-1:0]  r_pl1;
    logic [PW-1:0]  r_pl2;
    logic [PW-1:0]  r_pl3;
    logic [2:0]     r_vld;

    assign w_xs  = i_num[DW-1:SH];
    assign w_q   = QW'(r_prod >> KW);
    assign w_rem = r_num2 - r_qd2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[1:0], i_vld};
        end
        if (i_en) begin
            // stage 1: reciprocal product
            r_prod <= PRW'(w_xs) * PRW'(MAG);
            r_num1 <= i_num;
            r_pl1  <= i_pl;
            // stage 2: quotient and quotient times divisor
            r_q2   <= w_q;
            r_qd2  <= DW'(w_q) * DW'(DIV);
            r_num2 <= r_num1;
            r_pl2  <= r_pl1;
            // stage 3: remainder
            r_q3   <= r_q2;
            r_rem3 <= w_rem[DVW-1:0];
            r_pl3  <= r_pl2;
        end
    end

    assign o_vld = r_vld[2];
    assign o_q   = r_q3;
    assign o_rem = r_rem3;
    assign o_pl  = r_pl3;

endmodule

// ===== rtl/ecc_yrsrch.sv =====
// Year search: binary search of the year offset, one offset bit per stage.
module ecc_yrsrch #(
    parameter int PW = 1
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_vld,
    input  logic [ecc_pkg::DAYS_W-1:0] i_days,
    input  logic [PW-1:0]             i_pl,
    output logic                      o_vld,
    output logic [ecc_pkg::YEAR_W-1:0] o_year,
    output logic [ecc_pkg::DOY_W-1:0]  o_doy,
    output logic [PW-1:0]             o_pl
);
    import ecc_pkg::*;

    localparam int NST = YEAR_W;

    logic [YEAR_W-1:0] r_off  [NST];
    logic [DAYS_W-1:0] r_rem  [NST];
    logic [DAYS_W-1:0] r_days [NST];
    logic [PW-1:0]     r_pl   [NST];
    logic [NST-1:0]    r_vld;

    for (genvar gk = 0; gk < NST; gk++) begin : g_st
        localparam int B = NST - 1 - gk;

        logic [YEAR_W-1:0]  w_off;
        logic [DAYS_W-1:0]  w_rem;
        logic [DAYS_W-1:0]  w_days;
        logic [PW-1:0]      w_pl;
        logic               w_vld;
        logic [YEAR_W-1:0]  w_cand;
        logic [EDAYS_W-1:0] w_ed;
        logic               w_take;

        if (gk == 0) begin : g_first
            assign w_off  = '0;
            assign w_rem  = i_days;
            assign w_days = i_days;
            assign w_pl   = i_pl;
            assign w_vld  = i_vld;
        end else begin : g_next
            assign w_off  = r_off[gk-1];
            assign w_rem  = r_rem[gk-1];
            assign w_days = r_days[gk-1];
            assign w_pl   = r_pl[gk-1];
            assign w_vld  = r_vld[gk-1];
        end

        assign w_cand = w_off | (YEAR_W'(1) << B);
        assign w_ed   = epoch_days(YSRCH_W'(EPOCH_YEAR) + YSRCH_W'(w_cand));
        assign w_take = w_ed <= EDAYS_W'(w_days);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[gk] <= 1'b0;
            end else if (i_en) begin
                r_vld[gk] <= w_vld;
            end
            if (i_en) begin
                r_off[gk]  <= w_take ? w_cand : w_off;
                r_rem[gk]  <= w_take ? (w_days - w_ed[DAYS_W-1:0]) : w_rem;
                r_days[gk] <= w_days;
                r_pl[gk]   <= w_pl;
            end
        end
    end

    assign o_vld  = r_vld[NST-1];
    assign o_year = EPOCH_YEAR + r_off[NST-1];
    assign o_doy  = r_rem[NST-1][DOY_W-1:0];
    assign o_pl   = r_pl[NST-1];

endmodule

// ===== rtl/ecc_mon.sv =====
// Month walk: one stage for each month from January to November, subtracting month lengths from the day of year.
module ecc_mon #(
    parameter int PW = 1
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_vld,
    input  logic [ecc_pkg::YEAR_W-1:0] i_year,
    input  logic [ecc_pkg::DOY_W-1:0]  i_doy,
    input  logic [PW-1:0]              i_pl,
    output logic                       o_vld,
    output logic [ecc_pkg::YEAR_W-1:0] o_year,
    output logic [ecc_pkg::MON_W-1:0]  o_month,
    output logic [ecc_pkg::DAY_W-1:0]  o_day,
    output logic [PW-1:0]              o_pl
);
    import ecc_pkg::*;

    localparam int NST = 11;

    logic [YEAR_W-1:0] r_year [NST];
    logic [MON_W-1:0]  r_mon  [NST];
    logic [DOY_W-1:0]  r_doy  [NST];
    logic [NST-1:0]    r_lp;
    logic [PW-1:0]     r_pl   [NST];
    logic [NST-1:0]    r_vld;

    for (genvar gk = 0; gk < NST; gk++) begin : g_st
        localparam logic [MON_W-1:0] MK = MON_W'(gk + 1);

        logic [YEAR_W-1:0] w_year;
        logic [MON_W-1:0]  w_mon;
        logic [DOY_W-1:0]  w_doy;
        logic              w_lp;
        logic [PW-1:0]     w_pl;
        logic              w_vld;
        logic [DOY_W-1:0]  w_len;
        logic              w_step;

        if (gk == 0) begin : g_first
            assign w_year = i_year;
            assign w_mon  = MON_JAN;
            assign w_doy  = i_doy;
            assign w_lp   = is_leap(i_year);
            assign w_pl   = i_pl;
            assign w_vld  = i_vld;
        end else begin : g_next
            assign w_year = r_year[gk-1];
            assign w_mon  = r_mon[gk-1];
            assign w_doy  = r_doy[gk-1];
            assign w_lp   = r_lp[gk-1];
            assign w_pl   = r_pl[gk-1];
            assign w_vld  = r_vld[gk-1];
        end

        assign w_len  = DOY_W'(month_len(MK, w_lp));
        assign w_step = (w_mon == MK) && (w_doy >= w_len);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[gk] <= 1'b0;
            end else if (i_en) begin
                r_vld[gk] <= w_vld;
            end
            if (i_en) begin
                r_year[gk] <= w_year;
                r_mon[gk]  <= w_step ? (MK + MON_W'(1)) : w_mon;
                r_doy[gk]  <= w_step ? (w_doy - w_len) : w_doy;
                r_lp[gk]   <= w_lp;
                r_pl[gk]   <= w_pl;
            end
        end
    end

    assign o_vld   = r_vld[NST-1];
    assign o_year  = r_year[NST-1];
    assign o_month = r_mon[NST-1];
    assign o_day   = DAY_W'(r_doy[NST-1]) + DAY_W'(1);
    assign o_pl    = r_pl[NST-1];

endmodule

// ===== rtl/epoch_calendar_converter_unit.sv =====
// Epoch calendar converter: Unix seconds to and from Gregorian date, time and weekday.
//
// Converts between seconds since 1970-01-01 00:00:00 and a Gregorian date and time.
// i_func = 0 takes the calendar fields; i_func = 1 takes i_seconds_in (its low
// SECONDS_WIDTH bits). Every transaction yields one result transaction carrying the
// seconds count, the full date and time, the weekday (0 Monday .. 6 Sunday) and
// o_valid_res. An incorrect date (year before 1970, fields out of range, day past the
// month end), a date whose seconds do not fit SECONDS_WIDTH bits, or a seconds count at
// or beyond 4096-01-01 gives o_valid_res = 0 with every other field zero.
// The unit is a fully pipelined datapath: a new transaction may enter every cycle while
// o_stall is low. It passes 38 register stages: 5 front stages building the seconds
// count, 9 stages in three reciprocal-multiply dividers for days, hours, minutes and
// seconds, 12 year-search stages, 11 month stages and the output register. Both
// directions use the same path: a date is first turned into seconds, then decomposed
// again, which also yields the weekday.
// The whole pipeline advances together; o_stall is high while a finished result waits
// in the output register under i_stall.
module epoch_calendar_converter_unit #(
    parameter int SECONDS_WIDTH = ecc_pkg::SECONDS_WIDTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // input transaction channel
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic                       i_func,
    input  logic [ecc_pkg::YEAR_W-1:0] i_year_in,
    input  logic [ecc_pkg::MON_W-1:0]  i_month_in,
    input  logic [ecc_pkg::DAY_W-1:0]  i_day_in,
    input  logic [ecc_pkg::HOUR_W-1:0] i_hour_in,
    input  logic [ecc_pkg::MIN_W-1:0]  i_minute_in,
    input  logic [ecc_pkg::SEC_W-1:0]  i_second_in,
    input  logic [SECONDS_WIDTH-1:0]   i_seconds_in,
    // result transaction channel
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [SECONDS_WIDTH-1:0]   o_seconds_out,
    output logic [ecc_pkg::YEAR_W-1:0] o_year_out,
    output logic [ecc_pkg::MON_W-1:0]  o_month_out,
    output logic [ecc_pkg::DAY_W-1:0]  o_day_out,
    output logic [ecc_pkg::HOUR_W-1:0] o_hour_out,
    output logic [ecc_pkg::MIN_W-1:0]  o_minute_out,
    output logic [ecc_pkg::SEC_W-1:0]  o_second_out,
    output logic [ecc_pkg::WD_W-1:0]   o_weekday,
    output logic                       o_valid_res
);
    import ecc_pkg::*;

    localparam int SW   = SECONDS_WIDTH;
    localparam int FW   = (SW > PROD_W) ? SW : PROD_W;
    localparam int PL1_W = 1 + SW;
    localparam int PL2_W = PL1_W + DAYS_W + WD_W;
    localparam int PL3_W = PL2_W + HOUR_W;
    localparam int PLY_W = PL1_W + WD_W + HOUR_W + MIN_W + SEC_W;
    localparam int HR_REM_W = $clog2(SEC_PER_HOUR + 1);

    // global advance: every stage moves when the output register can take a result
    logic w_en;
    assign w_en    = !o_valid || !i_stall;
    assign o_stall = !w_en;

    // ---------------- stage 1: input register ----------------
    logic              r_p1_vld;
    logic              r_p1_func;
    logic [YEAR_W-1:0] r_p1_year;
    logic [MON_W-1:0]  r_p1_mon;
    logic [DAY_W-1:0]  r_p1_day;
    logic [HOUR_W-1:0] r_p1_hour;
    logic [MIN_W-1:0]  r_p1_min;
    logic [SEC_W-1:0]  r_p1_sec;
    logic [SW-1:0]     r_p1_secs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_vld <= 1'b0;
        end else if (w_en) begin
            r_p1_vld <= i_valid;
        end
        if (w_en) begin
            r_p1_func <= i_func;
            r_p1_year <= i_year_in;
            r_p1_mon  <= i_month_in;
            r_p1_day  <= i_day_in;
            r_p1_hour <= i_hour_in;
            r_p1_min  <= i_minute_in;
            r_p1_sec  <= i_second_in;
            r_p1_secs <= i_seconds_in;
        end
    end

    // ---------------- stage 2: date check, day of year, time of day ----------------
    logic             n_p2_lp;
    logic             n_p2_date_ok;
    logic [DOY_W-1:0] n_p2_doy;
    logic [HMS_W-1:0] n_p2_hms;

    assign n_p2_lp      = is_leap(r_p1_year);
    assign n_p2_date_ok = (r_p1_year >= EPOCH_YEAR) && (r_p1_sec <= SEC_W'(59))
                          && (r_p1_min <= MIN_W'(59)) && (r_p1_hour <= HOUR_W'(23))
                          && (r_p1_mon >= MON_JAN) && (r_p1_mon <= MON_DEC)
                          && (r_p1_day != '0)
                          && (r_p1_day <= month_len(r_p1_mon, n_p2_lp));
    assign n_p2_doy     = days_before_month(r_p1_mon, n_p2_lp)
                          + DOY_W'(r_p1_day) - DOY_W'(1);
    assign n_p2_hms     = HMS_W'(r_p1_hour) * HMS_W'(SEC_PER_HOUR)
                          + HMS_W'(r_p1_min) * HMS_W'(SEC_PER_MIN) + HMS_W'(r_p1_sec);

    logic              r_p2_vld;
    logic              r_p2_func;
    logic              r_p2_ok;
    logic [YEAR_W-1:0] r_p2_year;
    logic [DOY_W-1:0]  r_p2_doy;
    logic [HMS_W-1:0]  r_p2_hms;
    logic [SW-1:0]     r_p2_secs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p2_vld <= 1'b0;
        end else if (w_en) begin
            r_p2_vld <= r_p1_vld;
        end
        if (w_en) begin
            r_p2_func <= r_p1_func;
            r_p2_ok   <= r_p1_func || n_p2_date_ok;
            r_p2_year <= r_p1_year;
            r_p2_doy  <= n_p2_doy;
            r_p2_hms  <= n_p2_hms;
            r_p2_secs <= r_p1_secs;
        end
    end

    // ---------------- stage 3: epoch day count ----------------
    logic [EDAYS_W-1:0] n_p3_ed;
    assign n_p3_ed = epoch_days(YSRCH_W'(r_p2_year));

    logic              r_p3_vld;
    logic              r_p3_func;
    logic              r_p3_ok;
    logic [DAYS_W-1:0] r_p3_days;
    logic [HMS_W-1:0]  r_p3_hms;
    logic [SW-1:0]     r_p3_secs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p3_vld <= 1'b0;
        end else if (w_en) begin
            r_p3_vld <= r_p2_vld;
        end
        if (w_en) begin
            r_p3_func <= r_p2_func;
            r_p3_ok   <= r_p2_ok;
            r_p3_days <= n_p3_ed[DAYS_W-1:0] + DAYS_W'(r_p2_doy);
            r_p3_hms  <= r_p2_hms;
            r_p3_secs <= r_p2_secs;
        end
    end

    // ---------------- stage 4: days times seconds per day ----------------
    logic              r_p4_vld;
    logic              r_p4_func;
    logic              r_p4_ok;
    logic [PROD_W-1:0] r_p4_prod;
    logic [HMS_W-1:0]  r_p4_hms;
    logic [SW-1:0]     r_p4_secs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p4_vld <= 1'b0;
        end else if (w_en) begin
            r_p4_vld <= r_p3_vld;
        end
        if (w_en) begin
            r_p4_func <= r_p3_func;
            r_p4_ok   <= r_p3_ok;
            r_p4_prod <= PROD_W'(r_p3_days) * PROD_W'(SEC_PER_DAY);
            r_p4_hms  <= r_p3_hms;
            r_p4_secs <= r_p3_secs;
        end
    end

    // ---------------- stage 5: final seconds, width and range checks ----------------
    logic [FW-1:0] n_p5_full;
    logic [SW-1:0] n_p5_secs;
    logic          n_p5_ovf;
    logic          n_p5_in_range;

    assign n_p5_full     = FW'(r_p4_prod) + FW'(r_p4_hms);
    assign n_p5_ovf      = (n_p5_full >> SW) != '0;
    assign n_p5_secs     = r_p4_func ? r_p4_secs : n_p5_full[SW-1:0];
    assign n_p5_in_range = FW'(n_p5_secs) < FW'(END_SECS);

    logic          r_p5_vld;
    logic          r_p5_ok;
    logic [SW-1:0] r_p5_secs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p5_vld <= 1'b0;
        end else if (w_en) begin
            r_p5_vld <= r_p4_vld;
        end
        if (w_en) begin
            r_p5_ok   <= r_p4_ok && (r_p4_func || !n_p5_ovf) && n_p5_in_range;
            r_p5_secs <= n_p5_secs;
        end
    end

    // ---------------- seconds to days and seconds of day ----------------
    logic              w_d1_vld;
    logic [DAYS_W-1:0] w_d1_days;
    logic [HMS_W-1:0]  w_d1_rem;
    logic [PL1_W-1:0]  w_d1_pl;
    logic [WD_W-1:0]   w_d1_wd;

    ecc_divc #(
        .DW (SW),
        .QW (DAYS_W),
        .DIV(SEC_PER_DAY),
        .PW (PL1_W)
    ) u_div_day (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (w_en),
        .i_vld  (r_p5_vld),
        .i_num  (r_p5_secs),
        .i_pl   ({r_p5_ok, r_p5_secs}),
        .o_vld  (w_d1_vld),
        .o_q    (w_d1_days),
        .o_rem  (w_d1_rem),
        .o_pl   (w_d1_pl)
    );

    // 1970-01-01 was a Thursday
    assign w_d1_wd = mod7(EDAYS_W'(w_d1_days) + EDAYS_W'(3));

    // ---------------- hours ----------------
    logic                w_d2_vld;
    logic [HOUR_W-1:0]   w_d2_hour;
    logic [HR_REM_W-1:0] w_d2_rem;
    logic [PL2_W-1:0]    w_d2_pl;

    ecc_divc #(
        .DW (HMS_W),
        .QW (HOUR_W),
        .DIV(SEC_PER_HOUR),
        .PW (PL2_W)
    ) u_div_hour (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (w_en),
        .i_vld  (w_d1_vld),
        .i_num  (w_d1_rem),
        .i_pl   ({w_d1_pl, w_d1_days, w_d1_wd}),
        .o_vld  (w_d2_vld),
        .o_q    (w_d2_hour),
        .o_rem  (w_d2_rem),
        .o_pl   (w_d2_pl)
    );

    // ---------------- minutes and seconds ----------------
    logic              w_d3_vld;
    logic [MIN_W-1:0]  w_d3_min;
    logic [SEC_W-1:0]  w_d3_sec;
    logic [PL3_W-1:0]  w_d3_pl;
    logic [PL1_W-1:0]  w_d3_base;
    logic [DAYS_W-1:0] w_d3_days;
    logic [WD_W-1:0]   w_d3_wd;
    logic [HOUR_W-1:0] w_d3_hour;

    ecc_divc #(
        .DW (HR_REM_W),
        .QW (MIN_W),
        .DIV(SEC_PER_MIN),
        .PW (PL3_W)
    ) u_div_min (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (w_en),
        .i_vld  (w_d2_vld),
        .i_num  (w_d2_rem),
        .i_pl   ({w_d2_pl, w_d2_hour}),
        .o_vld  (w_d3_vld),
        .o_q    (w_d3_min),
        .o_rem  (w_d3_sec),
        .o_pl   (w_d3_pl)
    );

    assign {w_d3_base, w_d3_days, w_d3_wd, w_d3_hour} = w_d3_pl;

    // ---------------- year ----------------
    logic              w_y_vld;
    logic [YEAR_W-1:0] w_y_year;
    logic [DOY_W-1:0]  w_y_doy;
    logic [PLY_W-1:0]  w_y_pl;

    ecc_yrsrch #(
        .PW(PLY_W)
    ) u_yrsrch (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (w_en),
        .i_vld  (w_d3_vld),
        .i_days (w_d3_days),
        .i_pl   ({w_d3_base, w_d3_wd, w_d3_hour, w_d3_min, w_d3_sec}),
        .o_vld  (w_y_vld),
        .o_year (w_y_year),
        .o_doy  (w_y_doy),
        .o_pl   (w_y_pl)
    );

    // ---------------- month and day ----------------
    logic              w_m_vld;
    logic [YEAR_W-1:0] w_m_year;
    logic [MON_W-1:0]  w_m_mon;
    logic [DAY_W-1:0]  w_m_day;
    logic [PLY_W-1:0]  w_m_pl;
    logic              w_m_ok;
    logic [SW-1:0]     w_m_secs;
    logic [WD_W-1:0]   w_m_wd;
    logic [HOUR_W-1:0] w_m_hour;
    logic [MIN_W-1:0]  w_m_min;
    logic [SEC_W-1:0]  w_m_sec;

    ecc_mon #(
        .PW(PLY_W)
    ) u_mon (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (w_en),
        .i_vld  (w_y_vld),
        .i_year (w_y_year),
        .i_doy  (w_y_doy),
        .i_pl   (w_y_pl),
        .o_vld  (w_m_vld),
        .o_year (w_m_year),
        .o_month(w_m_mon),
        .o_day  (w_m_day),
        .o_pl   (w_m_pl)
    );

    assign {w_m_ok, w_m_secs, w_m_wd, w_m_hour, w_m_min, w_m_sec} = w_m_pl;

    // ---------------- output register; rejected transactions read as all zero ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (w_en) begin
            o_valid <= w_m_vld;
        end
        if (w_en) begin
            o_valid_res   <= w_m_ok;
            o_seconds_out <= w_m_ok ? w_m_secs : '0;
            o_year_out    <= w_m_ok ? w_m_year : '0;
            o_month_out   <= w_m_ok ? w_m_mon  : '0;
            o_day_out     <= w_m_ok ? w_m_day  : '0;
            o_hour_out    <= w_m_ok ? w_m_hour : '0;
            o_minute_out  <= w_m_ok ? w_m_min  : '0;
            o_second_out  <= w_m_ok ? w_m_sec  : '0;
            o_weekday     <= w_m_ok ? w_m_wd   : '0;
        end
    end

endmodule
